// ===== rtl/pled_pkg.sv =====
// Shared types and constants of the priority level event dispatcher.
`default_nettype none
package pled_pkg;

    localparam int NUM_EVENTS_DEF = 64;
    localparam int NUM_LEVELS_DEF = 32;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_SIGNAL  = 3'd1,
        CMD_CHECK   = 3'd2,
        CMD_CLOSE   = 3'd3,
        CMD_RAISE   = 3'd4,
        CMD_RESTORE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_BAD_LEVEL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_SIGNAL,
        OP_CHECK,
        OP_CLOSE,
        OP_RAISE,
        OP_RESTORE,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] event_id;
        logic [4:0] level;
        logic       has_notify;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       dispatched;
        logic [5:0] out_event;
        logic [4:0] out_level;
        logic [4:0] current_level;
        logic       irq_enable;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [5:0] event_id;
        logic [4:0] level;
        logic       has_notify;
        logic       lvl_ok;
    } t_work;

endpackage
`default_nettype wire

// ===== rtl/pled_front.sv =====
// Front end: command decode and a two-entry work queue.
`default_nettype none
module pled_front #(
    parameter int NUM_EVENTS = pled_pkg::NUM_EVENTS_DEF,
    parameter int NUM_LEVELS = pled_pkg::NUM_LEVELS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pled_pkg::t_in_item   i_item,
    output logic                 o_full,
    output logic                 o_valid,
    output pled_pkg::t_work      o_work,
    input  wire                  i_take
);
    pled_pkg::t_work r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    pled_pkg::t_work dec;
    logic            slot_ok;
    logic            wr;
    logic            rd;

    always_comb begin
        slot_ok        = 32'(i_item.event_id) < 32'(NUM_EVENTS);
        dec.event_id   = i_item.event_id;
        dec.level      = i_item.level;
        dec.has_notify = i_item.has_notify;
        dec.lvl_ok     = 32'(i_item.level) < 32'(NUM_LEVELS);
        unique case (i_item.cmd)
            pled_pkg::CMD_CREATE:  dec.op = slot_ok ? pled_pkg::OP_CREATE : pled_pkg::OP_BAD;
            pled_pkg::CMD_SIGNAL:  dec.op = slot_ok ? pled_pkg::OP_SIGNAL : pled_pkg::OP_BAD;
            pled_pkg::CMD_CHECK:   dec.op = slot_ok ? pled_pkg::OP_CHECK : pled_pkg::OP_BAD;
            pled_pkg::CMD_CLOSE:   dec.op = slot_ok ? pled_pkg::OP_CLOSE : pled_pkg::OP_BAD;
            pled_pkg::CMD_RAISE:   dec.op = pled_pkg::OP_RAISE;
            pled_pkg::CMD_RESTORE: dec.op = pled_pkg::OP_RESTORE;
            default:               dec.op = pled_pkg::OP_BAD;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_buf[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_buf[r_wp] <= dec;
                r_wp        <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pled_back.sv =====
// Back end: slot table, level queues and the dispatch sequencer.
`default_nettype none
module pled_back #(
    parameter int NUM_EVENTS = pled_pkg::NUM_EVENTS_DEF,
    parameter int NUM_LEVELS = pled_pkg::NUM_LEVELS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_work_valid,
    input  pled_pkg::t_work      i_work,
    output logic                 o_take,
    input  wire                  i_res_full,
    output logic                 o_res_push,
    output pled_pkg::t_out_item  o_res
);
    localparam int IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SIG, S_CLOSE, S_RS_FIND, S_RS_RD, S_RS_POP, S_RS_END
    } t_state;

    t_state                 r_state;
    logic [IW-1:0]          r_e;
    logic [LW-1:0]          r_q;
    logic [LW-1:0]          r_tgt;
    logic [LW-1:0]          r_cur;
    logic [NUM_LEVELS-1:0]  r_pend;
    logic [NUM_EVENTS-1:0]  r_in_use;
    logic [NUM_EVENTS-1:0]  r_sig;
    logic [NUM_EVENTS-1:0]  r_queued;
    logic [NUM_LEVELS-1:0]  r_qempty;
    logic [IW-1:0]          r_head [NUM_LEVELS];
    logic [IW-1:0]          r_tail [NUM_LEVELS];
    pled_pkg::t_out_item    r_hold;
    logic                   r_hold_v;

    logic [LW:0]            attr_mem [NUM_EVENTS];
    logic [IW-1:0]          next_mem [NUM_EVENTS];
    logic [IW-1:0]          prev_mem [NUM_EVENTS];
    logic [LW:0]            r_attr_q;
    logic [IW-1:0]          r_next_q;
    logic [IW-1:0]          r_prev_q;

    logic [IW-1:0]          widx;
    logic [LW-1:0]          wlvl;
    logic [IW-1:0]          rd_a;
    logic [LW-1:0]          aq;
    logic                   a_notify;
    logic                   p_found;
    logic [LW-1:0]          p_idx;
    logic                   raise_bad;
    logic                   rest_bad;
    logic                   create_ok;
    logic                   proceed;
    logic                   attr_we;
    logic                   nx_we;
    logic [IW-1:0]          nx_wa;
    logic [IW-1:0]          nx_wd;
    logic                   pv_we;
    logic [IW-1:0]          pv_wa;
    logic [IW-1:0]          pv_wd;

    function automatic logic irq_of(input logic [LW-1:0] l);
        return 32'(l) < 32'(NUM_LEVELS - 1);
    endfunction

    function automatic pled_pkg::t_out_item mk(input logic [1:0] st, input logic disp,
                                               input logic [IW-1:0] ev,
                                               input logic [LW-1:0] lv,
                                               input logic [LW-1:0] cur,
                                               input logic lst);
        pled_pkg::t_out_item r;
        r.status        = st;
        r.dispatched    = disp;
        r.out_event     = 6'(ev);
        r.out_level     = 5'(lv);
        r.current_level = 5'(cur);
        r.irq_enable    = irq_of(cur);
        r.last          = lst;
        return r;
    endfunction

    assign widx      = IW'(i_work.event_id);
    assign wlvl      = LW'(i_work.level);
    assign rd_a      = (r_state == S_IDLE) ? widx : r_e;
    assign aq        = r_attr_q[LW:1];
    assign a_notify  = r_attr_q[0];
    assign raise_bad = !i_work.lvl_ok || (wlvl < r_cur);
    assign rest_bad  = !i_work.lvl_ok || (wlvl > r_cur);
    assign create_ok = !r_in_use[widx] && i_work.lvl_ok;
    assign proceed   = !(r_hold_v && i_res_full);

    always_comb begin
        p_found = 1'b0;
        p_idx   = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_pend[i]) begin
                p_found = 1'b1;
                p_idx   = LW'(i);
            end
        end
    end

    always_comb begin
        o_take     = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        attr_we    = 1'b0;
        nx_we      = 1'b0;
        nx_wa      = r_tail[aq];
        nx_wd      = r_e;
        pv_we      = 1'b0;
        pv_wa      = r_e;
        pv_wd      = r_tail[aq];
        unique case (r_state)
            S_IDLE: begin
                if (i_work_valid && !i_res_full) begin
                    o_take = 1'b1;
                    unique case (i_work.op)
                        pled_pkg::OP_CREATE: begin
                            attr_we    = create_ok;
                            o_res_push = 1'b1;
                            o_res      = mk(create_ok ? pled_pkg::ST_OK : pled_pkg::ST_BAD_SLOT,
                                            1'b0, '0, '0, r_cur, 1'b1);
                        end
                        pled_pkg::OP_SIGNAL: begin
                            o_res_push = !r_in_use[widx] || r_sig[widx];
                            o_res      = mk(r_in_use[widx] ? pled_pkg::ST_OK
                                                           : pled_pkg::ST_BAD_SLOT,
                                            1'b0, '0, '0, r_cur, 1'b1);
                        end
                        pled_pkg::OP_CHECK: begin
                            o_res_push = 1'b1;
                            o_res      = mk(!r_in_use[widx] ? pled_pkg::ST_BAD_SLOT :
                                            r_sig[widx] ? pled_pkg::ST_OK
                                                        : pled_pkg::ST_NOT_READY,
                                            1'b0, '0, '0, r_cur, 1'b1);
                        end
                        pled_pkg::OP_CLOSE: begin
                            o_res_push = !r_in_use[widx] || !r_queued[widx];
                            o_res      = mk(r_in_use[widx] ? pled_pkg::ST_OK
                                                           : pled_pkg::ST_BAD_SLOT,
                                            1'b0, '0, '0, r_cur, 1'b1);
                        end
                        pled_pkg::OP_RAISE: begin
                            o_res_push = 1'b1;
                            o_res      = mk(raise_bad ? pled_pkg::ST_BAD_LEVEL : pled_pkg::ST_OK,
                                            1'b0, '0, r_cur, raise_bad ? r_cur : wlvl, 1'b1);
                        end
                        pled_pkg::OP_RESTORE: begin
                            o_res_push = rest_bad;
                            o_res      = mk(pled_pkg::ST_BAD_LEVEL, 1'b0, '0, '0, r_cur, 1'b1);
                        end
                        default: begin
                            o_res_push = 1'b1;
                            o_res      = mk(pled_pkg::ST_BAD_SLOT, 1'b0, '0, '0, r_cur, 1'b1);
                        end
                    endcase
                end
            end
            S_SIG: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = mk(pled_pkg::ST_OK, 1'b0, '0, '0, r_cur, 1'b1);
                    nx_we      = a_notify && !r_qempty[aq];
                    pv_we      = a_notify && !r_qempty[aq];
                end
            end
            S_CLOSE: begin
                nx_wa = r_prev_q;
                nx_wd = r_next_q;
                pv_wa = r_next_q;
                pv_wd = r_prev_q;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = mk(pled_pkg::ST_OK, 1'b0, '0, '0, r_cur, 1'b1);
                    nx_we      = (r_head[aq] != r_e) && (r_tail[aq] != r_e);
                    pv_we      = (r_head[aq] != r_e) && (r_tail[aq] != r_e);
                end
            end
            S_RS_POP: begin
                o_res_push = r_hold_v && proceed;
                o_res      = r_hold;
            end
            S_RS_END: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_hold_v) begin
                        o_res               = r_hold;
                        o_res.current_level = 5'(r_tgt);
                        o_res.irq_enable    = irq_of(r_tgt);
                        o_res.last          = 1'b1;
                    end else begin
                        o_res = mk(pled_pkg::ST_OK, 1'b0, '0, '0, r_tgt, 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_attr_q <= attr_mem[rd_a];
        r_next_q <= next_mem[rd_a];
        r_prev_q <= prev_mem[rd_a];
        if (attr_we) begin
            attr_mem[widx] <= {wlvl, i_work.has_notify};
        end
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= '0;
            r_in_use <= '0;
            r_sig    <= '0;
            r_queued <= '0;
            r_qempty <= '1;
            r_cur    <= LW'(NUM_LEVELS - 1);
            r_hold_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_e <= widx;
                        unique case (i_work.op)
                            pled_pkg::OP_CREATE: begin
                                if (create_ok) begin
                                    r_in_use[widx] <= 1'b1;
                                    r_sig[widx]    <= 1'b0;
                                    r_queued[widx] <= 1'b0;
                                end
                            end
                            pled_pkg::OP_SIGNAL: begin
                                if (r_in_use[widx] && !r_sig[widx]) begin
                                    r_state <= S_SIG;
                                end
                            end
                            pled_pkg::OP_CHECK: begin
                                if (r_in_use[widx] && r_sig[widx]) begin
                                    r_sig[widx] <= 1'b0;
                                end
                            end
                            pled_pkg::OP_CLOSE: begin
                                if (r_in_use[widx]) begin
                                    if (r_queued[widx]) begin
                                        r_state <= S_CLOSE;
                                    end else begin
                                        r_in_use[widx] <= 1'b0;
                                        r_sig[widx]    <= 1'b0;
                                    end
                                end
                            end
                            pled_pkg::OP_RAISE: begin
                                if (!raise_bad) begin
                                    r_cur <= wlvl;
                                end
                            end
                            pled_pkg::OP_RESTORE: begin
                                if (!rest_bad) begin
                                    r_tgt    <= wlvl;
                                    r_hold_v <= 1'b0;
                                    r_state  <= S_RS_FIND;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SIG: begin
                    if (!i_res_full) begin
                        r_sig[r_e] <= 1'b1;
                        if (a_notify) begin
                            if (r_qempty[aq]) begin
                                r_head[aq]   <= r_e;
                                r_qempty[aq] <= 1'b0;
                            end
                            r_tail[aq]    <= r_e;
                            r_queued[r_e] <= 1'b1;
                            r_pend[aq]    <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CLOSE: begin
                    if (!i_res_full) begin
                        priority if (r_head[aq] == r_e && r_tail[aq] == r_e) begin
                            r_qempty[aq] <= 1'b1;
                        end else if (r_head[aq] == r_e) begin
                            r_head[aq] <= r_next_q;
                        end else if (r_tail[aq] == r_e) begin
                            r_tail[aq] <= r_prev_q;
                        end else begin
                        end
                        r_queued[r_e] <= 1'b0;
                        r_in_use[r_e] <= 1'b0;
                        r_sig[r_e]    <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                S_RS_FIND: begin
                    if (p_found && p_idx > r_tgt) begin
                        r_q   <= p_idx;
                        r_cur <= p_idx;
                        if (r_qempty[p_idx]) begin
                            r_pend[p_idx] <= 1'b0;
                        end else begin
                            r_e     <= r_head[p_idx];
                            r_state <= S_RS_RD;
                        end
                    end else begin
                        r_state <= S_RS_END;
                    end
                end
                S_RS_RD: begin
                    r_state <= S_RS_POP;
                end
                S_RS_POP: begin
                    if (proceed) begin
                        if (r_tail[r_q] == r_e) begin
                            r_qempty[r_q] <= 1'b1;
                        end else begin
                            r_head[r_q] <= r_next_q;
                        end
                        r_queued[r_e] <= 1'b0;
                        r_sig[r_e]    <= 1'b0;
                        r_hold        <= mk(pled_pkg::ST_OK, 1'b1, r_e, r_q, r_q, 1'b0);
                        r_hold_v      <= 1'b1;
                        r_state       <= S_RS_FIND;
                    end
                end
                S_RS_END: begin
                    if (!i_res_full) begin
                        r_cur    <= r_tgt;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pled_outq.sv =====
// Two-entry result queue in front of the result ports.
`default_nettype none
module pled_outq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pled_pkg::t_out_item  i_res,
    output logic                 o_full,
    output logic                 o_empty,
    output pled_pkg::t_out_item  o_item,
    input  wire                  i_pop
);
    pled_pkg::t_out_item r_buf [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                wr;
    logic                rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_buf[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_buf[r_wp] <= i_res;
                r_wp        <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/priority_level_event_dispatcher.sv =====
// Top level of the priority level event dispatcher.
// Path: a command is registered in the work queue, taken by the sequencer and its result
//   registered in the result queue; signal and close may first pass a table-read state.
// Sequencing: create, check, raise and failed commands finish in the idle state; signal
//   and close may pass a table-read state; restore finds, reads and pops each pending
//   event above the target, then ends; a state with a result waits on a full result queue.
// Reset (synchronous): flags, pending mask cleared, queue-empty bits set, level set to top;
//   slot attribute and link memories are not cleared and hold data only once written.
`default_nettype none
module priority_level_event_dispatcher #(
    parameter int NUM_EVENTS = pled_pkg::NUM_EVENTS_DEF,
    parameter int NUM_LEVELS = pled_pkg::NUM_LEVELS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pled_pkg::t_in_item   i_item,
    output logic                 o_full,
    output logic                 o_empty,
    output pled_pkg::t_out_item  o_item,
    input  wire                  i_pop
);
    logic                work_valid;
    pled_pkg::t_work     work;
    logic                take;
    logic                res_full;
    logic                res_push;
    pled_pkg::t_out_item res;

    pled_front #(
        .NUM_EVENTS(NUM_EVENTS),
        .NUM_LEVELS(NUM_LEVELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_valid (work_valid),
        .o_work  (work),
        .i_take  (take)
    );

    pled_back #(
        .NUM_EVENTS(NUM_EVENTS),
        .NUM_LEVELS(NUM_LEVELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_take       (take),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    pled_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (o_empty),
        .o_item  (o_item),
        .i_pop   (i_pop)
    );

    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full) else $error("result pushed into full queue");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> work_valid) else $error("work taken from empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full)) else $error("queues not empty after reset");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res.dispatched) |-> (res.status == pled_pkg::ST_OK))
        else $error("dispatch result with error status");
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the priority level event dispatcher.
`timescale 1ns / 1ps
module testbench;

    localparam int NEV = 64;
    localparam int NLV = 32;
    localparam int TOP = NLV - 1;
    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    pled_pkg::t_in_item i_item = '0;
    logic o_full, o_empty;
    pled_pkg::t_out_item o_item;

    priority_level_event_dispatcher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_item),
        .o_full(o_full), .o_empty(o_empty), .o_item(o_item), .i_pop(i_pop)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // dispatcher model state
    logic [4:0] m_cur;
    logic [31:0] m_pend;
    bit m_used[NEV], m_sig[NEV], m_queued[NEV], m_notify[NEV];
    logic [4:0] m_lvl[NEV];
    int lvl_fifo[NLV][$];

    pled_pkg::t_in_item cmd_q[$];
    pled_pkg::t_out_item result_q[$];
    int errors = 0;
    int cycles = 0;
    bit rx_hold = 0;
    bit tx_drain = 0;

    function automatic pled_pkg::t_out_item mk(logic [1:0] st, logic d, logic [5:0] ev,
                                               logic [4:0] ol, logic [4:0] cl, logic lst);
        pled_pkg::t_out_item r;
        r.status = st; r.dispatched = d; r.out_event = ev; r.out_level = ol;
        r.current_level = cl; r.irq_enable = (cl < TOP); r.last = lst;
        return r;
    endfunction

    function automatic void drop_from_level(int e);
        int q;
        q = m_lvl[e];
        for (int k = 0; k < lvl_fifo[q].size(); k++)
            if (lvl_fifo[q][k] == e) begin
                lvl_fifo[q].delete(k);
                break;
            end
        m_queued[e] = 0;
    endfunction

    function automatic void predict_dispatch(pled_pkg::t_in_item it);
        logic [1:0] st;
        int e, tgt, p, n, h;
        logic [4:0] old;
        pled_pkg::t_out_item lr;
        st = pled_pkg::ST_OK;
        e = it.event_id;
        case (it.cmd)
            pled_pkg::CMD_CREATE, pled_pkg::CMD_SIGNAL, pled_pkg::CMD_CHECK,
            pled_pkg::CMD_CLOSE: begin
                if (it.cmd == pled_pkg::CMD_CREATE) begin
                    if (m_used[e]) st = pled_pkg::ST_BAD_SLOT;
                    else begin
                        m_used[e] = 1; m_sig[e] = 0; m_queued[e] = 0;
                        m_lvl[e] = it.level; m_notify[e] = it.has_notify;
                    end
                end else if (!m_used[e]) st = pled_pkg::ST_BAD_SLOT;
                else if (it.cmd == pled_pkg::CMD_SIGNAL) begin
                    if (!m_sig[e]) begin
                        m_sig[e] = 1;
                        if (m_notify[e]) begin
                            lvl_fifo[m_lvl[e]].push_back(e);
                            m_queued[e] = 1;
                            m_pend[m_lvl[e]] = 1'b1;
                        end
                    end
                end else if (it.cmd == pled_pkg::CMD_CHECK) begin
                    if (m_sig[e]) m_sig[e] = 0;
                    else st = pled_pkg::ST_NOT_READY;
                end else begin
                    if (m_queued[e]) drop_from_level(e);
                    m_used[e] = 0; m_sig[e] = 0;
                end
                result_q.push_back(mk(st, 0, 0, 0, m_cur, 1));
            end
            pled_pkg::CMD_RAISE: begin
                old = m_cur;
                if (it.level < old)
                    result_q.push_back(mk(pled_pkg::ST_BAD_LEVEL, 0, 0, old, old, 1));
                else begin
                    m_cur = it.level;
                    result_q.push_back(mk(pled_pkg::ST_OK, 0, 0, old, m_cur, 1));
                end
            end
            pled_pkg::CMD_RESTORE: begin
                tgt = it.level;
                n = 0;
                if (tgt > m_cur)
                    result_q.push_back(mk(pled_pkg::ST_BAD_LEVEL, 0, 0, 0, m_cur, 1));
                else begin
                    for (p = TOP; p > tgt; p--) begin
                        if (!m_pend[p]) continue;
                        while (lvl_fifo[p].size() > 0) begin
                            h = lvl_fifo[p].pop_front();
                            m_queued[h] = 0; m_sig[h] = 0;
                            result_q.push_back(mk(pled_pkg::ST_OK, 1, 6'(h), 5'(p), 5'(p), 0));
                            n++;
                        end
                        m_pend[p] = 1'b0;
                    end
                    m_cur = 5'(tgt);
                    if (n > 0) begin
                        lr = result_q.pop_back();
                        lr.current_level = 5'(tgt);
                        lr.irq_enable = (tgt < TOP);
                        lr.last = 1'b1;
                        result_q.push_back(lr);
                    end else result_q.push_back(mk(pled_pkg::ST_OK, 0, 0, 0, 5'(tgt), 1));
                end
            end
            default: result_q.push_back(mk(pled_pkg::ST_BAD_SLOT, 0, 0, 0, m_cur, 1));
        endcase
    endfunction

    function automatic pled_pkg::t_in_item cmd_item(logic [2:0] c, int e, int l, bit nt);
        pled_pkg::t_in_item it;
        it.cmd = c; it.event_id = 6'(e); it.level = 5'(l); it.has_notify = nt;
        return it;
    endfunction

    // sampled handshake flags
    logic o_full_s = 1'b1;
    bit accepted_pending = 0;
    always @(posedge i_clk) begin
        o_full_s <= o_full;
        accepted_pending <= i_push && !o_full;
    end

    // driver
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full_s) begin
                predict_dispatch(i_item);
                void'(cmd_q.pop_front());
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_push <= 1'b0;
            end else if (tx_drain && (cmd_q.size() == 0 || result_q.size() > 0 ||
                                      accepted_pending)) begin
                i_push <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                i_push <= 1'b1;
                i_item <= cmd_q[0];
                if ($urandom_range(0, 4) == 0)
                    tx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end else i_push <= 1'b0;
        end
    end

    // monitor / receiver
    int rx_gap = 0;
    pled_pkg::t_out_item want;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_pop && !o_empty) begin
            if (result_q.size() == 0) begin
                $error("unexpected result %p", o_item);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_item.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_item.status); errors++; end
                if (o_item.dispatched !== want.dispatched) begin
                    $error("dispatched exp %0d got %0d", want.dispatched,
                           o_item.dispatched); errors++; end
                if (o_item.out_event !== want.out_event) begin
                    $error("out_event exp %0d got %0d", want.out_event,
                           o_item.out_event); errors++; end
                if (o_item.out_level !== want.out_level) begin
                    $error("out_level exp %0d got %0d", want.out_level,
                           o_item.out_level); errors++; end
                if (o_item.current_level !== want.current_level) begin
                    $error("current_level exp %0d got %0d", want.current_level,
                           o_item.current_level); errors++; end
                if (o_item.irq_enable !== want.irq_enable) begin
                    $error("irq_enable exp %0d got %0d", want.irq_enable,
                           o_item.irq_enable); errors++; end
                if (o_item.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_item.last); errors++; end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold) i_pop <= 1'b0;
        else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk)
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end

    // stimulus
    int r, e, l, k, hold_n;
    initial begin
        m_cur = TOP; m_pend = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CHECK, 0, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, 0, 31, 1));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, 63, 0, 1));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, 63, 5, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, 21, 10, 1));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, 42, 10, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, 0, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, 0, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, 21, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, 42, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CHECK, 42, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CHECK, 42, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, 63, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CLOSE, 21, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_CLOSE, 21, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_RAISE, 0, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_RESTORE, 0, 31, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_RESTORE, 0, 0, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_RESTORE, 0, 5, 0));
        cmd_q.push_back(cmd_item(pled_pkg::CMD_RAISE, 0, 31, 0));
        cmd_q.push_back(cmd_item(3'd6, 63, 31, 1));
        cmd_q.push_back(cmd_item(3'd7, 0, 0, 0));
        for (k = 0; k < 64; k += 21) cmd_q.push_back(cmd_item(pled_pkg::CMD_CLOSE, k, 0, 0));
        wait (cmd_q.size() == 0 && result_q.size() == 0);

        // receiver holds off while the sender keeps pushing
        rx_hold = 1;
        for (k = 0; k < 40; k++)
            cmd_q.push_back(cmd_item(pled_pkg::CMD_CHECK, $urandom_range(0, 63), 0, 0));
        hold_n = 0;
        while (hold_n < 300) begin
            @(posedge i_clk);
            hold_n++;
        end
        rx_hold = 0;

        // random, mostly well-formed create/signal/check/close/raise/restore sequences
        for (int it = 0; it < 290; it++) begin
            r = $urandom_range(0, 99);
            e = $urandom_range(0, 63);
            l = $urandom_range(0, 31);
            if (r < 20)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_CREATE, e, l,
                                         $urandom_range(0, 7) != 0));
            else if (r < 50)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_SIGNAL, e, l, $urandom_range(0, 1)));
            else if (r < 58)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_CHECK, e, l, $urandom_range(0, 1)));
            else if (r < 66)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_CLOSE, e, l, $urandom_range(0, 1)));
            else if (r < 78)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_RAISE, e, 31, 0));
            else if (r < 95)
                cmd_q.push_back(cmd_item(pled_pkg::CMD_RESTORE, e,
                                         $urandom_range(0, 3) == 0 ? l : 0, 0));
            else
                cmd_q.push_back(cmd_item(3'($urandom_range(4, 7)), e, l,
                                         $urandom_range(0, 1)));
            if (it == 150) begin
                tx_drain = 1;
                wait (cmd_q.size() == 0 && result_q.size() == 0 && !accepted_pending);
                tx_drain = 0;
            end
        end
        wait (cmd_q.size() == 0 && !i_push);
        wait (result_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pled_pkg.sv
rtl/pled_front.sv
rtl/pled_back.sv
rtl/pled_outq.sv
rtl/priority_level_event_dispatcher.sv
sim/testbench.sv
